// ===== rtl/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Shared constants, field widths, codes and types of the frequency sorted table.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KIND_W  = 1;
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 16;
  localparam int POS_W   = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SEARCH,
    ST_BUBBLE,
    ST_PLACE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   entry_key;
    logic [COUNT_W-1:0] entry_count;
    logic [POS_W-1:0]   position;
    logic               is_new;
    logic               dropped;
    logic               present;
  } result_t;

endpackage

// ===== rtl/fst_if.sv =====
// ----------------------------------------------------------------------------
// fst_in_if / fst_out_if
// Valid/ready channels for requests into the table and results out of it.
// ----------------------------------------------------------------------------
interface fst_in_if;
  import fst_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output kind, output key, output index, input ready);
  modport sink   (input valid, input kind, input key, input index, output ready);
endinterface

interface fst_out_if;
  import fst_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   entry_key;
  logic [COUNT_W-1:0] entry_count;
  logic [POS_W-1:0]   position;
  logic               is_new;
  logic               dropped;
  logic               present;

  modport source (output valid, output entry_key, output entry_count, output position,
                  output is_new, output dropped, output present, input ready);
  modport sink   (input valid, input entry_key, input entry_count, input position,
                  input is_new, input dropped, input present, output ready);
endinterface

// ===== rtl/frequency_sorted_table.sv =====
// ----------------------------------------------------------------------------
// frequency_sorted_table
// Table of keys with repeat counts kept in order of count, high to low.
//
//   Channel  Direction  Payload                                          
//   in_ch    sink       kind, key, index                                 
//   out_ch   source     entry_key, entry_count, position, is_new,        
//                       dropped, present                                 
//
// A read goes through ST_RD_WAIT to the output register, or straight to ST_FIN
// past the fill level. An add searches the positions one after another from the
// head, and a hit below the head that is not saturated then moves the entry toward
// the head one position at a time through ST_BUBBLE and, if it reaches the head,
// ST_PLACE; the single read port of the entry memory sets this pace. A full output
// register holds the finished result back in ST_FIN until it is free.
// Reset empties the table at once; there is no clearing pass.
// A new request is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module frequency_sorted_table #(
  parameter int CAPACITY   = fst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = fst_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = fst_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fst_in_if.sink    in_ch,
  fst_out_if.source out_ch
);
  import fst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + COUNT_BITS;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic          res_valid;
  logic          res_ready;
  result_t       res;

  fst_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fst_ctrl #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/fst_ram.sv =====
// ----------------------------------------------------------------------------
// fst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fst_ctrl
// Sequencer that serves reads, searches the table, bumps counts, shifts entries
// toward the head and appends new keys through the entry memory.
// ----------------------------------------------------------------------------
module fst_ctrl #(
  parameter int CAPACITY   = fst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = fst_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = fst_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fst_in_if.sink                               in_ch,
  output logic                                 ram_we,
  output logic [$clog2(CAPACITY)-1:0]          ram_waddr,
  output logic [KEY_BITS+COUNT_BITS-1:0]       ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]          ram_raddr,
  input  logic [KEY_BITS+COUNT_BITS-1:0]       ram_rdata,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output fst_pkg::result_t                     res
);
  import fst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int XW = (FW > INDEX_W) ? FW : INDEX_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  state_t                state_r, state_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [AW-1:0]         scan_r, scan_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  result_t               res_r, res_nxt;

  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [KEY_BITS-1:0]   in_key;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [AW-1:0]         pos_dec;

  assign rd_key  = ram_rdata[KEY_BITS+COUNT_BITS-1:COUNT_BITS];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
  assign in_key  = KEY_BITS'(in_ch.key);
  assign cnt_inc = rd_cnt + COUNT_BITS'(1);
  assign pos_dec = pos_r - AW'(1);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_FIN);
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    scan_r <= scan_nxt;
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    key_nxt   = key_r;
    scan_nxt  = scan_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = {key_r, cnt_r};
    ram_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (kind_t'(in_ch.kind) == KIND_READ) begin
            res_nxt.position = POS_W'(in_ch.index);
            res_nxt.is_new   = 1'b0;
            res_nxt.dropped  = 1'b0;
            if (XW'(in_ch.index) < XW'(fill_r)) begin
              ram_raddr = AW'(in_ch.index);
              state_nxt = ST_RD_WAIT;
            end else begin
              res_nxt.entry_key   = '0;
              res_nxt.entry_count = '0;
              res_nxt.present     = 1'b0;
              state_nxt           = ST_FIN;
            end
          end else begin
            key_nxt = in_key;
            if (fill_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_key, {COUNT_BITS{1'b0}}};
              fill_nxt  = FW'(1);
              res_nxt   = '{entry_key: KEY_W'(in_key), entry_count: '0, position: '0,
                            is_new: 1'b1, dropped: 1'b0, present: 1'b1};
              state_nxt = ST_FIN;
            end else begin
              ram_raddr = '0;
              scan_nxt  = '0;
              state_nxt = ST_SEARCH;
            end
          end
        end
      end

      ST_RD_WAIT: begin
        res_nxt.entry_key   = KEY_W'(rd_key);
        res_nxt.entry_count = COUNT_W'(rd_cnt);
        res_nxt.present     = 1'b1;
        state_nxt           = ST_FIN;
      end

      ST_SEARCH: begin
        ram_raddr = scan_r + AW'(1);
        if (rd_key == key_r) begin
          res_nxt.entry_key = KEY_W'(key_r);
          res_nxt.is_new    = 1'b0;
          res_nxt.dropped   = 1'b0;
          res_nxt.present   = 1'b1;
          if (rd_cnt == CMAX) begin
            res_nxt.entry_count = COUNT_W'(rd_cnt);
            res_nxt.position    = POS_W'(scan_r);
            state_nxt           = ST_FIN;
          end else if (scan_r == '0) begin
            ram_we              = 1'b1;
            ram_waddr           = '0;
            ram_wdata           = {key_r, cnt_inc};
            res_nxt.entry_count = COUNT_W'(cnt_inc);
            res_nxt.position    = '0;
            state_nxt           = ST_FIN;
          end else begin
            ram_raddr = scan_r - AW'(1);
            pos_nxt   = scan_r;
            cnt_nxt   = cnt_inc;
            state_nxt = ST_BUBBLE;
          end
        end else if ((FW'(scan_r) + FW'(1)) == fill_r) begin
          if (fill_r < FW'(CAPACITY)) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(fill_r);
            ram_wdata = {key_r, {COUNT_BITS{1'b0}}};
            fill_nxt  = fill_r + FW'(1);
            res_nxt   = '{entry_key: KEY_W'(key_r), entry_count: '0,
                          position: POS_W'(fill_r), is_new: 1'b1, dropped: 1'b0,
                          present: 1'b1};
          end else begin
            res_nxt   = '{entry_key: KEY_W'(key_r), entry_count: '0, position: '0,
                          is_new: 1'b0, dropped: 1'b1, present: 1'b0};
          end
          state_nxt = ST_FIN;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end

      ST_BUBBLE: begin
        if (rd_cnt < cnt_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_dec;
          if (pos_dec == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_raddr = pos_r - AW'(2);
          end
        end else begin
          ram_we              = 1'b1;
          res_nxt.entry_count = COUNT_W'(cnt_r);
          res_nxt.position    = POS_W'(pos_r);
          state_nxt           = ST_FIN;
        end
      end

      ST_PLACE: begin
        ram_we              = 1'b1;
        res_nxt.entry_count = COUNT_W'(cnt_r);
        res_nxt.position    = POS_W'(pos_r);
        state_nxt           = ST_FIN;
      end

      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fst_out_stage.sv =====
// ----------------------------------------------------------------------------
// fst_out_stage
// Output register that holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module fst_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  fst_pkg::result_t res,
  fst_out_if.source        out_ch
);
  import fst_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign res_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.entry_key   = data_r.entry_key;
  assign out_ch.entry_count = data_r.entry_count;
  assign out_ch.position    = data_r.position;
  assign out_ch.is_new      = data_r.is_new;
  assign out_ch.dropped     = data_r.dropped;
  assign out_ch.present     = data_r.present;

endmodule

// ===== rtl/fst_checker.sv =====
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks of the frequency sorted table, bound to the top level.
// ----------------------------------------------------------------------------
module fst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fst_pkg::KEY_W-1:0]   out_entry_key,
  input logic [fst_pkg::COUNT_W-1:0] out_entry_count,
  input logic [fst_pkg::POS_W-1:0]   out_position,
  input logic                        out_is_new,
  input logic                        out_dropped,
  input logic                        out_present
);
  import fst_pkg::*;

  // The sequencer works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_key)
      && $stable(out_entry_count) && $stable(out_position) && $stable(out_present))
    else $error("stalled result changed");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_present && !out_is_new
      && out_entry_count == '0 && out_position == '0)
    else $error("dropped result carries entry data");

  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> out_present && !out_dropped && out_entry_count == '0)
    else $error("new entry result is inconsistent");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_present && !out_dropped |-> out_entry_key == '0
      && out_entry_count == '0 && !out_is_new)
    else $error("read past fill level returned data");

endmodule

bind frequency_sorted_table fst_checker u_fst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_entry_key   (out_ch.entry_key),
  .out_entry_count (out_ch.entry_count),
  .out_position    (out_ch.position),
  .out_is_new      (out_ch.is_new),
  .out_dropped     (out_ch.dropped),
  .out_present     (out_ch.present)
);
